>>> sv/dkbc_pkg.sv
package dkbc_pkg;

  localparam int unsigned RUN_COUNT_WIDTH_DEF = 32;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned SLOT_W = $clog2(MAX_RESULTS);
  localparam int unsigned NUM_W = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  // All results caused by one input item. At most one of them is a run item,
  // so the run count travels beside the group and not per slot.
  typedef struct packed {
    logic [NUM_W-1:0]                  num;
    logic [MAX_RESULTS-1:0][7:0]       slot_byte;
    logic [MAX_RESULTS-1:0]            slot_blank;
    logic                              done;
  } grp_t;

endpackage

>>> sv/dkbc_front.sv
module dkbc_front #(
  parameter int unsigned RUN_COUNT_WIDTH = dkbc_pkg::RUN_COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       end_of_body_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output dkbc_pkg::grp_t             grp_o,
  output logic [RUN_COUNT_WIDTH-1:0] run_o
);
  import dkbc_pkg::*;

  logic                       relaxed_q;
  logic                       held_cr_q, held_cr_d;
  logic [RUN_COUNT_WIDTH-1:0] pend_q, pend_d;
  logic                       ws_q, ws_d;
  logic                       lc_q, lc_d;
  logic                       ae_q, ae_d;
  logic                       accept;
  grp_t                       grp;
  logic [RUN_COUNT_WIDTH-1:0] run;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relaxed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      relaxed_q <= cfg_data_i;
    end
  end

  always_comb begin
    logic [NUM_W-1:0] n;
    logic [1:0]       do_content;
    logic [1:0][7:0]  content_byte;
    logic             is_ws;
    held_cr_d = held_cr_q;
    pend_d    = pend_q;
    ws_d      = ws_q;
    lc_d      = lc_q;
    ae_d      = ae_q;
    n         = '0;
    grp       = '0;
    run       = '0;
    is_ws     = (in_byte_i == CH_SP) || (in_byte_i == CH_TAB);
    do_content   = '0;
    content_byte = '0;
    if (end_of_body_i) begin
      if (relaxed_q) begin
        if (lc_q || !ae_q) begin
          grp.slot_byte[n[SLOT_W-1:0]] = CH_CR;
          n = n + NUM_W'(1);
          grp.slot_byte[n[SLOT_W-1:0]] = CH_LF;
          n = n + NUM_W'(1);
        end else begin
          // Nothing left to send: a zero-length run item marks the end.
          grp.slot_blank[n[SLOT_W-1:0]] = 1'b1;
          n = n + NUM_W'(1);
        end
      end else begin
        if (held_cr_q) begin
          if (pend_q != '0) begin
            grp.slot_blank[n[SLOT_W-1:0]] = 1'b1;
            run = pend_q;
            n = n + NUM_W'(1);
          end
          grp.slot_byte[n[SLOT_W-1:0]] = CH_CR;
          n = n + NUM_W'(1);
        end
        grp.slot_byte[n[SLOT_W-1:0]] = CH_CR;
        n = n + NUM_W'(1);
        grp.slot_byte[n[SLOT_W-1:0]] = CH_LF;
        n = n + NUM_W'(1);
      end
      grp.done  = 1'b1;
      held_cr_d = 1'b0;
      pend_d    = '0;
      ws_d      = 1'b0;
      lc_d      = 1'b0;
      ae_d      = 1'b0;
    end else if (relaxed_q) begin
      if (in_byte_i == CH_LF) begin
        if (lc_q) begin
          grp.slot_byte[n[SLOT_W-1:0]] = CH_CR;
          n = n + NUM_W'(1);
          grp.slot_byte[n[SLOT_W-1:0]] = CH_LF;
          n = n + NUM_W'(1);
        end else if (pend_q != '1) begin
          pend_d = pend_q + RUN_COUNT_WIDTH'(1);
        end
        held_cr_d = 1'b0;
        ws_d      = 1'b0;
        lc_d      = 1'b0;
      end else begin
        // A held CR not followed by LF is content, ahead of this byte.
        do_content[0]   = held_cr_q;
        content_byte[0] = CH_CR;
        do_content[1]   = (in_byte_i != CH_CR) && !is_ws;
        content_byte[1] = in_byte_i;
        held_cr_d       = 1'b0;
        for (int k = 0; k < 2; k++) begin
          if (do_content[k]) begin
            if (!lc_d) begin
              if (pend_d != '0) begin
                grp.slot_blank[n[SLOT_W-1:0]] = 1'b1;
                run = pend_d;
                n = n + NUM_W'(1);
              end
              pend_d = '0;
              lc_d   = 1'b1;
            end
            if (ws_d) begin
              grp.slot_byte[n[SLOT_W-1:0]] = CH_SP;
              n = n + NUM_W'(1);
              ws_d = 1'b0;
            end
            grp.slot_byte[n[SLOT_W-1:0]] = content_byte[k];
            n = n + NUM_W'(1);
            ae_d = 1'b1;
          end
        end
        if (in_byte_i == CH_CR) begin
          held_cr_d = 1'b1;
        end else if (is_ws) begin
          ws_d = 1'b1;
        end
      end
    end else begin
      if (in_byte_i == CH_LF) begin
        held_cr_d = 1'b0;
        if (pend_q != '1) begin
          pend_d = pend_q + RUN_COUNT_WIDTH'(1);
        end
      end else begin
        if (held_cr_q || (in_byte_i != CH_CR)) begin
          if (pend_q != '0) begin
            grp.slot_blank[n[SLOT_W-1:0]] = 1'b1;
            run = pend_q;
            n = n + NUM_W'(1);
          end
          pend_d = '0;
        end
        if (held_cr_q) begin
          grp.slot_byte[n[SLOT_W-1:0]] = CH_CR;
          n = n + NUM_W'(1);
        end
        held_cr_d = (in_byte_i == CH_CR);
        if (in_byte_i != CH_CR) begin
          grp.slot_byte[n[SLOT_W-1:0]] = in_byte_i;
          n = n + NUM_W'(1);
        end
      end
    end
    grp.num = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cr_q <= 1'b0;
      pend_q    <= '0;
      ws_q      <= 1'b0;
      lc_q      <= 1'b0;
      ae_q      <= 1'b0;
    end else if (accept) begin
      held_cr_q <= held_cr_d;
      pend_q    <= pend_d;
      ws_q      <= ws_d;
      lc_q      <= lc_d;
      ae_q      <= ae_d;
    end
  end

  assign push_o = accept && (grp.num != '0);
  assign grp_o  = grp;
  assign run_o  = run;

endmodule

>>> sv/dkbc_queue.sv
module dkbc_queue #(
  parameter int unsigned RUN_COUNT_WIDTH = dkbc_pkg::RUN_COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  dkbc_pkg::grp_t             push_grp_i,
  input  logic [RUN_COUNT_WIDTH-1:0] push_run_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       head_valid_o,
  output dkbc_pkg::grp_t             head_grp_o,
  output logic [RUN_COUNT_WIDTH-1:0] head_run_o
);
  import dkbc_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  grp_t                       grp_mem [QUEUE_DEPTH];
  logic [RUN_COUNT_WIDTH-1:0] run_mem [QUEUE_DEPTH];
  logic [AW-1:0]              wr_q, rd_q;
  logic [CW-1:0]              cnt_q;
  logic                       do_pop;

  assign full_o       = (cnt_q == CW'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_grp_o   = grp_mem[rd_q];
  assign head_run_o   = run_mem[rd_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      grp_mem[wr_q] <= push_grp_i;
      run_mem[wr_q] <= push_run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

>>> sv/dkbc_back.sv
module dkbc_back #(
  parameter int unsigned RUN_COUNT_WIDTH = dkbc_pkg::RUN_COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  dkbc_pkg::grp_t             head_grp_i,
  input  logic [RUN_COUNT_WIDTH-1:0] head_run_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       is_blank_run_o,
  output logic [RUN_COUNT_WIDTH-1:0] run_count_o,
  output logic                       last_of_item_o,
  output logic                       body_done_o
);
  import dkbc_pkg::*;

  logic                       out_valid_q;
  logic [SLOT_W-1:0]          idx_q;
  logic [7:0]                 byte_q;
  logic                       blank_q;
  logic [RUN_COUNT_WIDTH-1:0] run_q;
  logic                       last_q;
  logic                       done_q;
  logic                       load;
  logic                       is_last;
  logic                       take;

  assign load    = !out_valid_q || !out_stall_i;
  assign take    = load && head_valid_i;
  assign is_last = ({1'b0, idx_q} == NUM_W'(head_grp_i.num - NUM_W'(1)));
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= head_valid_i;
      if (head_valid_i) begin
        idx_q <= is_last ? '0 : idx_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      blank_q <= head_grp_i.slot_blank[idx_q];
      byte_q  <= head_grp_i.slot_byte[idx_q];
      run_q   <= head_grp_i.slot_blank[idx_q] ? head_run_i : '0;
      last_q  <= is_last;
      done_q  <= is_last && head_grp_i.done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign is_blank_run_o = blank_q;
  assign run_count_o    = run_q;
  assign last_of_item_o = last_q;
  assign body_done_o    = done_q;

endmodule

>>> sv/dkim_body_canonicalizer_top.sv
// Accepted items go into the group queue; the output stage registers their results.
// Throughput: one item is accepted per cycle while the four-entry group queue has room;
// the output stage sends one result per cycle while out_stall is low, and an item
// with k results (1 to 4) is popped with its last result; the queue absorbs bursts.
// Reset (rst_ni, asynchronous, active low) empties the queue and output stage, clears
// the stream state and selects simple mode.
module dkim_body_canonicalizer_top #(
  parameter int unsigned RUN_COUNT_WIDTH = dkbc_pkg::RUN_COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data_i,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte_i,
  input  logic                       end_of_body_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte_o,
  output logic                       is_blank_run_o,
  output logic [RUN_COUNT_WIDTH-1:0] run_count_o,
  output logic                       last_of_item_o,
  output logic                       body_done_o
);
  import dkbc_pkg::*;

  logic                       push;
  grp_t                       push_grp;
  logic [RUN_COUNT_WIDTH-1:0] push_run;
  logic                       q_full;
  logic                       pop;
  logic                       head_valid;
  grp_t                       head_grp;
  logic [RUN_COUNT_WIDTH-1:0] head_run;

  assign cfg_ready = 1'b1;

  dkbc_front #(.RUN_COUNT_WIDTH(RUN_COUNT_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid && cfg_ready),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_byte_i     (in_byte_i),
    .end_of_body_i (end_of_body_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .grp_o         (push_grp),
    .run_o         (push_run)
  );

  dkbc_queue #(.RUN_COUNT_WIDTH(RUN_COUNT_WIDTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_grp_i   (push_grp),
    .push_run_i   (push_run),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_grp_o   (head_grp),
    .head_run_o   (head_run)
  );

  dkbc_back #(.RUN_COUNT_WIDTH(RUN_COUNT_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_grp_i     (head_grp),
    .head_run_i     (head_run),
    .pop_o          (pop),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte_o),
    .is_blank_run_o (is_blank_run_o),
    .run_count_o    (run_count_o),
    .last_of_item_o (last_of_item_o),
    .body_done_o    (body_done_o)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("group pushed into a full queue");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall && end_of_body_i) |-> push)
    else $error("end of body produced no result group");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && body_done_o) |-> last_of_item_o)
    else $error("body_done on a result that is not the last of its item");

  a_byte_item_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !is_blank_run_o) |-> (run_count_o == '0))
    else $error("byte result carries a nonzero run count");
`endif

endmodule

>>> verif/tb_dkim_body_canonicalizer_top.sv
module tb_dkim_body_canonicalizer_top;
  import dkbc_pkg::*;

  // The block is built with an 8-bit run counter.
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned NUM_DIR    = 34;
  localparam int unsigned NUM_RANDOM = 180;
  localparam logic        MODE_SIMPLE  = 1'b0;
  localparam logic        MODE_RELAXED = 1'b1;

  typedef struct packed {
    logic [7:0]       ch;
    logic             blank;
    logic [RUN_W-1:0] cnt;
    logic             last;
    logic             done;
  } canon_res_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_END, ROW_MODE} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] val;
    logic       lit_ok;
    canon_res_t lit;
  } row_t;

  localparam canon_res_t NO_LIT = '0;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_data_i;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_byte_i;
  logic             end_of_body_i;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte_o;
  logic             is_blank_run_o;
  logic [RUN_W-1:0] run_count_o;
  logic             last_of_item_o;
  logic             body_done_o;

  logic             gap_free;
  int unsigned      n_err;

  // Shadow of the canonicalizer state.
  logic             p_mode;
  logic             p_held_cr;
  logic             p_ws;
  logic             p_content;
  logic             p_emitted;
  logic [RUN_W-1:0] p_pend;

  canon_res_t step_q[$];
  canon_res_t canon_q[$];
  row_t       dir_tab[NUM_DIR];

  dkim_body_canonicalizer_top #(
    .RUN_COUNT_WIDTH(RUN_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data_i    (cfg_data_i),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_i     (in_byte_i),
    .end_of_body_i (end_of_body_i),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte_o    (out_byte_o),
    .is_blank_run_o(is_blank_run_o),
    .run_count_o   (run_count_o),
    .last_of_item_o(last_of_item_o),
    .body_done_o   (body_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
    n_err++;
  endtask

  function automatic void put_res(input logic [7:0] ch, input logic blank,
                                  input logic [RUN_W-1:0] cnt);
    canon_res_t res;
    res = '{ch, blank, cnt, 1'b0, 1'b0};
    if (step_q.size() < MAX_RESULTS) begin
      step_q.insert(step_q.size(), res);
    end
  endfunction

  function automatic void flush_pend();
    if (p_pend != '0) begin
      put_res(8'h00, 1'b1, p_pend);
      p_pend = '0;
    end
  endfunction

  function automatic void relaxed_content(input logic [7:0] c);
    if (!p_content) begin
      flush_pend();
      p_content = 1'b1;
    end
    if (p_ws) begin
      put_res(CH_SP, 1'b0, '0);
      p_ws = 1'b0;
    end
    put_res(c, 1'b0, '0);
    p_emitted = 1'b1;
  endfunction

  // Works out the canonical output of one body byte or end mark into step_q.
  function automatic void canon_step(input logic [7:0] c, input logic eob);
    step_q.delete();
    if (eob) begin
      if (p_mode == MODE_RELAXED) begin
        if (p_content || !p_emitted) begin
          put_res(CH_CR, 1'b0, '0);
          put_res(CH_LF, 1'b0, '0);
        end
        // An empty run item marks the end when nothing else is left.
        if (step_q.size() == 0) begin
          put_res(8'h00, 1'b1, '0);
        end
      end else begin
        if (p_held_cr) begin
          flush_pend();
          put_res(CH_CR, 1'b0, '0);
        end
        put_res(CH_CR, 1'b0, '0);
        put_res(CH_LF, 1'b0, '0);
      end
      p_held_cr = 1'b0;
      p_pend    = '0;
      p_ws      = 1'b0;
      p_content = 1'b0;
      p_emitted = 1'b0;
    end else if (p_mode == MODE_RELAXED) begin
      if (c == CH_LF) begin
        if (p_content) begin
          put_res(CH_CR, 1'b0, '0);
          put_res(CH_LF, 1'b0, '0);
        end else if (p_pend != '1) begin
          p_pend = p_pend + 1'b1;
        end
        p_held_cr = 1'b0;
        p_ws      = 1'b0;
        p_content = 1'b0;
      end else begin
        if (p_held_cr) begin
          p_held_cr = 1'b0;
          relaxed_content(CH_CR);
        end
        if (c == CH_CR) begin
          p_held_cr = 1'b1;
        end else if (c == CH_SP || c == CH_TAB) begin
          p_ws = 1'b1;
        end else begin
          relaxed_content(c);
        end
      end
    end else begin
      if (c == CH_LF) begin
        p_held_cr = 1'b0;
        if (p_pend != '1) begin
          p_pend = p_pend + 1'b1;
        end
      end else begin
        if (p_held_cr) begin
          flush_pend();
          put_res(CH_CR, 1'b0, '0);
          p_held_cr = 1'b0;
        end
        if (c == CH_CR) begin
          p_held_cr = 1'b1;
        end else begin
          flush_pend();
          put_res(c, 1'b0, '0);
        end
      end
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size()-1].last = 1'b1;
      step_q[step_q.size()-1].done = eob;
    end
  endfunction

  task automatic feed_item(input logic [7:0] b, input logic eob, input logic lit_ok,
                           input canon_res_t lit);
    int unsigned gap;
    gap = gap_free ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    in_byte_i     <= b;
    end_of_body_i <= eob;
    do @(posedge clk_i); while (in_stall);
    canon_step(b, eob);
    if (lit_ok) begin
      canon_q.insert(canon_q.size(), lit);
    end else begin
      foreach (step_q[k]) canon_q.insert(canon_q.size(), step_q[k]);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (canon_q.size() != 0) @(posedge clk_i);
    // Items without output are never pushed into the group queue.
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain_results();
    cfg_valid  <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_mode = m;
  endtask

  initial begin
    int unsigned n_stall;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      n_stall = gap_free ? 0 : $urandom_range(0, 7);
      if (n_stall != 0) begin
        out_stall <= 1'b1;
        repeat (n_stall) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin : check_results
    canon_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (canon_q.size() == 0) begin
        report_mismatch("result with nothing expected",
                        {out_byte_o, is_blank_run_o, run_count_o}, '0);
      end else begin
        want = canon_q.pop_front();
        if (out_byte_o !== want.ch) begin
          report_mismatch("out_byte", out_byte_o, want.ch);
        end
        if (is_blank_run_o !== want.blank) begin
          report_mismatch("is_blank_run", is_blank_run_o, want.blank);
        end
        if (run_count_o !== want.cnt) begin
          report_mismatch("run_count", run_count_o, want.cnt);
        end
        if (last_of_item_o !== want.last) begin
          report_mismatch("last_of_item", last_of_item_o, want.last);
        end
        if (body_done_o !== want.done) begin
          report_mismatch("body_done", body_done_o, want.done);
        end
      end
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned len;
    int unsigned r;
    int unsigned waited;
    in_valid      = 1'b0;
    in_byte_i     = 8'h00;
    end_of_body_i = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data_i    = 1'b0;
    rst_ni        = 1'b0;
    gap_free      = 1'b0;
    n_err         = 0;
    p_mode        = MODE_SIMPLE;
    p_held_cr     = 1'b0;
    p_pend        = '0;
    p_ws          = 1'b0;
    p_content     = 1'b0;
    p_emitted     = 1'b0;

    // Simple mode straight out of reset, then relaxed corner cases, then a
    // mode switch in the middle of a body.
    dir_tab = '{
      '{ROW_BYTE, 8'h41,  1'b1, '{8'h41, 1'b0, '0, 1'b1, 1'b0}},
      '{ROW_BYTE, 8'h00,  1'b1, '{8'h00, 1'b0, '0, 1'b1, 1'b0}},
      '{ROW_BYTE, 8'hFF,  1'b1, '{8'hFF, 1'b0, '0, 1'b1, 1'b0}},
      '{ROW_BYTE, CH_CR,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_LF,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_LF,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_CR,  1'b0, NO_LIT},
      '{ROW_BYTE, 8'h62,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_CR,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_CR,  1'b0, NO_LIT},
      '{ROW_END,  8'hFF,  1'b0, NO_LIT},
      '{ROW_MODE, 8'(MODE_RELAXED), 1'b0, NO_LIT},
      '{ROW_END,  8'h00,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_SP,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_TAB, 1'b0, NO_LIT},
      '{ROW_BYTE, 8'h78,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_SP,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_CR,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_LF,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_LF,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_CR,  1'b0, NO_LIT},
      '{ROW_BYTE, 8'h7A,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_LF,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_LF,  1'b0, NO_LIT},
      '{ROW_END,  8'h00,  1'b0, NO_LIT},
      '{ROW_BYTE, 8'h71,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_CR,  1'b0, NO_LIT},
      '{ROW_END,  8'h00,  1'b0, NO_LIT},
      '{ROW_BYTE, CH_SP,  1'b0, NO_LIT},
      '{ROW_MODE, 8'(MODE_SIMPLE), 1'b0, NO_LIT},
      '{ROW_BYTE, 8'h6D,  1'b0, NO_LIT},
      '{ROW_MODE, 8'(MODE_RELAXED), 1'b0, NO_LIT},
      '{ROW_BYTE, 8'h6E,  1'b0, NO_LIT},
      '{ROW_END,  8'h00,  1'b0, NO_LIT}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_MODE: begin
          write_mode(dir_tab[i].val[0]);
        end
        ROW_END: begin
          feed_item(dir_tab[i].val, 1'b1, dir_tab[i].lit_ok, dir_tab[i].lit);
        end
        default: begin
          feed_item(dir_tab[i].val, 1'b0, dir_tab[i].lit_ok, dir_tab[i].lit);
        end
      endcase
    end

    // Random bodies made of text lines, whitespace runs and line breaks, with
    // some arbitrary bytes mixed in. The mode may change in mid body.
    n_rand = 0;
    while (n_rand < NUM_RANDOM) begin
      if ($urandom_range(0, 2) != 0) begin
        write_mode(1'($urandom_range(0, 1)));
      end
      gap_free = ($urandom_range(0, 3) == 0);
      len = $urandom_range(10, 30);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          feed_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0, 1'b0, NO_LIT);
        end else if (r < 55) begin
          feed_item($urandom_range(0, 1) ? CH_SP : CH_TAB, 1'b0, 1'b0, NO_LIT);
        end else if (r < 70) begin
          feed_item(CH_LF, 1'b0, 1'b0, NO_LIT);
        end else if (r < 78) begin
          feed_item(CH_CR, 1'b0, 1'b0, NO_LIT);
        end else if (r < 86) begin
          feed_item(CH_CR, 1'b0, 1'b0, NO_LIT);
          feed_item(CH_LF, 1'b0, 1'b0, NO_LIT);
          n_rand++;
        end else if (r < 96) begin
          feed_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_LIT);
        end else begin
          feed_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_LIT);
        end
        n_rand++;
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (canon_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (canon_q.size() != 0) begin
      report_mismatch("results never delivered", canon_q.size(), 0);
    end
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dkbc_pkg.sv
sv/dkbc_front.sv
sv/dkbc_queue.sv
sv/dkbc_back.sv
sv/dkim_body_canonicalizer_top.sv
verif/tb_dkim_body_canonicalizer_top.sv
